// File: hdl/kmns_pkg.sv
// Shared types and constants for the key matrix MIDI note scanner.
// No dependencies; used by kmns_lane, kmns_merge and the top level.
package kmns_pkg;

   localparam int COL_MAX = 8;                   // width of the column sample field
   localparam logic [8:0] SEMITONES = 9'd12;
   localparam logic [8:0] NOTE_MAX = 9'd127;
   localparam logic [31:0] NOTE_ON_BASE = 32'h0990_0000;
   localparam logic [31:0] NOTE_OFF_BASE = 32'h0880_0000;
   localparam logic [3:0] OCTAVE_RESET = 4'd2;
   localparam logic [6:0] VELOCITY_RESET = 7'h40;

   // register indexes on the csr port
   localparam logic [7:0] CSR_OCTAVE_OFFSET = 8'd0;
   localparam logic [7:0] CSR_NOTE_VELOCITY = 8'd1;

   localparam int RSP_DATA_W = 48;

   // what one column lane found for the current sample
   typedef struct packed {
      logic       fire;
      logic       on;
      logic [6:0] note;
   } kmns_event_type;

endpackage

// File: hdl/kmns_lane.sv
// One column lane: change detect and note number for a single column.
// Depends on kmns_pkg.
module kmns_lane
   import kmns_pkg::*;
(
   input  logic           new_bit,
   input  logic           old_bit,
   input  logic [2:0]     col_idx,
   input  logic [3:0]     row,
   input  logic           note_row,
   input  logic [3:0]     octave,
   output kmns_event_type evt
);

   logic [8:0] note_full;

   always_comb begin
      note_full = SEMITONES * 9'(octave) + 9'(row) + SEMITONES * 9'(col_idx);
      evt.fire  = note_row && (new_bit != old_bit) && (note_full <= NOTE_MAX);
      evt.on    = new_bit;
      evt.note  = note_full[6:0];
   end

endmodule

// File: hdl/kmns_merge.sv
// Merge stage: holds the lane results of one sample and sends them out lowest
// column first, one item per cycle while rsp_tready is high. Depends on kmns_pkg.
module kmns_merge
   import kmns_pkg::*;
#(
   parameter int LANES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  kmns_event_type        lane_events [LANES],
   input  logic [6:0]            velocity,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  can_load
);

   logic [LANES-1:0]      pend_ff, pend_in;
   logic [LANES-1:0]      on_ff, on_in;
   logic [LANES-1:0][6:0] note_ff, note_in;
   logic [LANES-1:0]      sel;
   logic                  found;
   logic                  sel_on;
   logic [6:0]            sel_note;
   logic [31:0]           word;
   logic                  fire;

   // lowest pending lane
   always_comb begin
      sel      = '0;
      found    = 1'b0;
      sel_on   = 1'b0;
      sel_note = '0;
      for (int i = 0; i < LANES; i++) begin
         if (pend_ff[i] && !found) begin
            sel[i] = 1'b1;
            found  = 1'b1;
         end
      end
      for (int i = 0; i < LANES; i++) begin
         sel_on   = sel_on | (sel[i] & on_ff[i]);
         sel_note = sel_note | ({7{sel[i]}} & note_ff[i]);
      end
   end

   always_comb begin
      rsp_tvalid = |pend_ff;
      rsp_tlast  = ~|(pend_ff & ~sel);
      fire       = rsp_tvalid && rsp_tready;
      can_load   = !rsp_tvalid || (rsp_tready && rsp_tlast);
      word       = (sel_on ? NOTE_ON_BASE : NOTE_OFF_BASE) | {16'd0, 1'b0, sel_note, 8'd0}
                   | {25'd0, velocity};
      rsp_tdata  = {1'b0, word, velocity, sel_note, sel_on};
   end

   always_comb begin
      pend_in = pend_ff;
      on_in   = on_ff;
      note_in = note_ff;
      if (load) begin
         for (int i = 0; i < LANES; i++) begin
            pend_in[i] = lane_events[i].fire;
            on_in[i]   = lane_events[i].on;
            note_in[i] = lane_events[i].note;
         end
      end else if (fire) begin
         pend_in = pend_ff & ~sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      on_ff   <= on_in;
      note_ff <= note_in;
   end

endmodule

// File: hdl/key_matrix_midi_note_scanner.sv
// Top level of the key matrix scanner producing USB-MIDI note events.
// Depends on kmns_pkg, kmns_lane and kmns_merge.
//
//  channel | dir | handshake               | payload
//  req     | in  | req_tvalid / req_tready | tdata[7:0] column_bits
//  rsp     | out | rsp_tvalid / rsp_tready | tdata: note on, note, velocity, word; tlast
//  csr     | in  | csr_valid / csr_ready   | csr_index, csr_data
//
// One column lane per key column compares the sample with the stored row in
// the cycle the item is taken; the merge register then emits one event per
// cycle while rsp_tready is high; a sample causes 0 to 8 events. The next
// sample is taken in the cycle the final event leaves, or at once when
// nothing is waiting. Reset is synchronous and clears the row counter, the
// stored rows, the registers and the pending events. A stalled rsp_tready
// stalls req_tready once the merge register is full.
module key_matrix_midi_note_scanner
   import kmns_pkg::*;
#(
   parameter int ROW_COUNT    = 16,
   parameter int NOTE_ROWS    = 12,
   parameter int COLUMN_COUNT = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // column sample item
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] column_bits
   // note event item
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] is_note_on, [7:1] note_number,
                                              // [14:8] velocity_byte,
                                              // [46:15] usb_midi_word, [47] zero
   output logic                  rsp_tlast,   // last_of_scan
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [7:0]            csr_index,
   input  logic [7:0]            csr_data
);

   localparam int ROW_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROW_COUNT - 1);

   logic [3:0]              octave_ff, octave_in;
   logic [6:0]              velocity_ff, velocity_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [COLUMN_COUNT-1:0] rows_ff [ROW_COUNT];
   logic [COLUMN_COUNT-1:0] sample;
   logic [COLUMN_COUNT-1:0] stored;
   logic                    note_row;
   logic                    accept;
   logic                    can_load;
   kmns_event_type          lane_events [COLUMN_COUNT];

   assign csr_ready  = 1'b1;
   assign req_tready = can_load;
   assign accept     = req_tvalid && req_tready;
   assign sample     = req_tdata[COLUMN_COUNT-1:0];
   assign stored     = rows_ff[row_ff];
   assign note_row   = 32'(row_ff) < NOTE_ROWS;

   // register writes; unknown indexes are dropped
   always_comb begin
      octave_in   = octave_ff;
      velocity_in = velocity_ff;
      if (csr_valid) begin
         priority if (csr_index == CSR_OCTAVE_OFFSET) begin
            octave_in = csr_data[3:0];
         end else if (csr_index == CSR_NOTE_VELOCITY) begin
            velocity_in = csr_data[6:0];
         end
      end
   end

   always_comb begin
      row_in = row_ff;
      if (accept) begin
         row_in = (row_ff == ROW_LAST) ? '0 : row_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         octave_ff   <= OCTAVE_RESET;
         velocity_ff <= VELOCITY_RESET;
         row_ff      <= '0;
      end else begin
         octave_ff   <= octave_in;
         velocity_ff <= velocity_in;
         row_ff      <= row_in;
      end
   end

   // last sample of each row
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROW_COUNT; r++) begin
            rows_ff[r] <= '0;
         end
      end else if (accept) begin
         rows_ff[row_ff] <= sample;
      end
   end

   for (genvar c = 0; c < COLUMN_COUNT; c++) begin : g_lane
      kmns_lane u_lane (
         .new_bit  (sample[c]),
         .old_bit  (stored[c]),
         .col_idx  (3'(c)),
         .row      (4'(row_ff)),
         .note_row (note_row),
         .octave   (octave_ff),
         .evt      (lane_events[c])
      );
   end

   kmns_merge #(
      .LANES (COLUMN_COUNT)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .lane_events (lane_events),
      .velocity    (velocity_ff),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .can_load    (can_load)
   );

   // a new sample only lands when the previous one's events are all gone
   a_load_when_drained: assert property (@(posedge clock) disable iff (reset)
      accept |-> (!rsp_tvalid || (rsp_tready && rsp_tlast)))
      else $error("sample taken over pending events");

   // a control row never causes an event
   a_control_row_quiet: assert property (@(posedge clock) disable iff (reset)
      (accept && !note_row) |=> !rsp_tvalid)
      else $error("event from a control row");

   // nothing pending straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("event pending after reset");

endmodule

// File: test/tb_top.sv
// Self-checking bench for the key matrix MIDI note scanner.
// Needs kmns_pkg and key_matrix_midi_note_scanner; reads no files.
// Samples go in row by row, note events are predicted and checked in order.
module tb_top
   import kmns_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROW_COUNT    = 16;
   localparam int NOTE_ROWS    = 12;
   localparam int COLUMN_COUNT = 8;
   localparam logic [7:0] COLUMN_MASK =
      (COLUMN_COUNT >= 8) ? 8'hFF : 8'((1 << COLUMN_COUNT) - 1);

   // indexes that map to no register; writes to them must change nothing
   localparam logic [7:0] CSR_UNMAPPED_LOW = 8'd2;
   localparam logic [7:0] CSR_UNMAPPED_TOP = 8'hFF;

   localparam int DRAIN_CYCLES = 24;    // covers a sample still in the merge stage
   localparam int STUCK_LIMIT  = 4000;  // cycles without any handshake
   localparam int HALF_PHASE   = 44;

   // one expected note event as it appears on the rsp channel
   typedef struct packed {
      logic        on;
      logic [6:0]  note;
      logic [6:0]  velocity;
      logic [31:0] word;
      logic        last;
   } note_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'h00;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [7:0]            csr_index  = 8'h00;
   logic [7:0]            csr_data   = 8'h00;

   key_matrix_midi_note_scanner #(
      .ROW_COUNT   (ROW_COUNT),
      .NOTE_ROWS   (NOTE_ROWS),
      .COLUMN_COUNT(COLUMN_COUNT)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Predictor state: our own copy of the registers, row counter and
   // stored rows, advanced only on accepted handshakes.
   // ---------------------------------------------------------------
   logic [3:0]  octave_setting   = OCTAVE_RESET;
   logic [6:0]  velocity_setting = VELOCITY_RESET;
   logic [3:0]  row_ptr          = 4'd0;
   logic [7:0]  stored_rows [ROW_COUNT];
   note_event_type expected_events [$];

   // stimulus side
   logic [7:0]  sample_queue [$];
   logic [7:0]  shadow_rows [ROW_COUNT];   // what the generator believes is stored
   logic [3:0]  scan_pos = 4'd0;
   int          sender_idle_pct    = 0;
   int          receiver_stall_pct = 0;

   // bookkeeping
   int items_pushed   = 0;
   int items_accepted = 0;
   int events_checked = 0;
   int csr_writes     = 0;
   int error_count    = 0;
   int stuck_cycles   = 0;
   logic req_handshake = 1'b0;

   initial begin
      foreach (stored_rows[i]) stored_rows[i] = 8'h00;
      foreach (shadow_rows[i]) shadow_rows[i] = 8'h00;
   end

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
      error_count++;
   endtask

   // register write as the block sees it: low bits kept, unknown index dropped
   function automatic void apply_register(input logic [7:0] index, input logic [7:0] value);
      if (index == CSR_OCTAVE_OFFSET)
         octave_setting = value[3:0];
      else if (index == CSR_NOTE_VELOCITY)
         velocity_setting = value[6:0];
   endfunction

   // Works out the note events caused by one column sample and queues them.
   // Changed bits on a note row give one event each, rising column order;
   // notes above 127 are dropped, control rows only store the sample.
   function automatic void predict_note_events(input logic [7:0] raw);
      note_event_type batch [$];
      note_event_type ev;
      logic [7:0]  sample;
      logic [7:0]  changed;
      int          note;
      sample  = raw & COLUMN_MASK;
      changed = sample ^ stored_rows[row_ptr];
      if (int'(row_ptr) < NOTE_ROWS) begin
         for (int c = 0; c < COLUMN_COUNT; c++) begin
            note = int'(SEMITONES) * int'(octave_setting) + int'(row_ptr)
                 + int'(SEMITONES) * c;
            if (changed[c] && note <= int'(NOTE_MAX)) begin
               ev.on       = sample[c];
               ev.note     = 7'(note);
               ev.velocity = velocity_setting;
               ev.word     = (sample[c] ? NOTE_ON_BASE : NOTE_OFF_BASE)
                           | (32'(note) << 8) | 32'(velocity_setting);
               ev.last     = 1'b0;
               batch.push_back(ev);
            end
         end
         if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
         foreach (batch[i]) expected_events.push_back(batch[i]);
      end
      stored_rows[row_ptr] = sample;
      row_ptr = (int'(row_ptr) + 1 >= ROW_COUNT) ? 4'd0 : row_ptr + 4'd1;
   endfunction

   // ---------------------------------------------------------------
   // Driver: changes inputs on the falling edge. A presented item is
   // held until the rising edge that takes it; gaps and stalls drawn
   // per cycle from the current idle percentages.
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_handshake) begin
         // item still waiting for req_tready, keep it as it is
      end else if (sample_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
         req_tvalid <= 1'b1;
         req_tdata  <= sample_queue.pop_front();
      end else begin
         req_tvalid <= 1'b0;
      end
      rsp_tready <= !reset && ($urandom_range(99) >= receiver_stall_pct);
   end

   // ---------------------------------------------------------------
   // Monitor: everything sampled on the rising edge. Results are checked
   // against the oldest expectation before the new item is predicted.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      note_event_type want;
      req_handshake = !reset && req_tvalid && req_tready;
      if (reset) begin
         octave_setting   = OCTAVE_RESET;
         velocity_setting = VELOCITY_RESET;
         row_ptr          = 4'd0;
         foreach (stored_rows[i]) stored_rows[i] = 8'h00;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_events.size() == 0) begin
               flag_mismatch("note event with none expected", rsp_tdata[46:15], 32'h0);
            end else begin
               want = expected_events.pop_front();
               if (rsp_tdata[0] !== want.on)
                  flag_mismatch("is_note_on", 32'(rsp_tdata[0]), 32'(want.on));
               if (rsp_tdata[7:1] !== want.note)
                  flag_mismatch("note_number", 32'(rsp_tdata[7:1]), 32'(want.note));
               if (rsp_tdata[14:8] !== want.velocity)
                  flag_mismatch("velocity_byte", 32'(rsp_tdata[14:8]), 32'(want.velocity));
               if (rsp_tdata[46:15] !== want.word)
                  flag_mismatch("usb_midi_word", rsp_tdata[46:15], want.word);
               if (rsp_tdata[47] !== 1'b0)
                  flag_mismatch("tdata pad bit", 32'(rsp_tdata[47]), 32'h0);
               if (rsp_tlast !== want.last)
                  flag_mismatch("last_of_scan", 32'(rsp_tlast), 32'(want.last));
            end
            events_checked++;
         end
         if (req_handshake) begin
            predict_note_events(req_tdata);
            items_accepted++;
         end
         if (csr_valid && csr_ready) begin
            apply_register(csr_index, csr_data);
            csr_writes++;
         end
         if (req_handshake || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
            stuck_cycles = 0;
         else
            stuck_cycles++;
      end
   end

   // watchdog: nothing moving on any channel for too long ends the run
   initial begin
      do @(posedge clock); while (stuck_cycles < STUCK_LIMIT);
      $display("watchdog: no handshake for %0d cycles, %0d events outstanding",
               STUCK_LIMIT, expected_events.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   function automatic void queue_sample(input logic [7:0] value);
      sample_queue.push_back(value);
      shadow_rows[scan_pos] = value & COLUMN_MASK;
      scan_pos = (int'(scan_pos) + 1 >= ROW_COUNT) ? 4'd0 : scan_pos + 4'd1;
      items_pushed++;
   endfunction

   // mostly realistic key activity: one or two keys toggling on the row
   // about to be scanned, some unchanged rows, some arbitrary noise
   function automatic logic [7:0] random_sample();
      logic [7:0] prev;
      logic [7:0] result;
      int         pick;
      prev = shadow_rows[scan_pos];
      pick = $urandom_range(99);
      if (pick < 60) begin
         result = prev ^ (8'h01 << $urandom_range(7));
         if (pick < 20)
            result = result ^ (8'h01 << $urandom_range(7));
      end else if (pick < 75) begin
         result = prev;
      end else begin
         result = 8'($urandom);
      end
      return result;
   endfunction

   task automatic write_csr(input logic [7:0] index, input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // sender holds off until every sample is taken and every event is in,
   // then a further drain wait for a sample that caused no event
   task automatic wait_drained();
      do @(negedge clock);
      while (items_accepted != items_pushed || expected_events.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin
      logic [7:0] first_scan [ROW_COUNT];
      int idle_by_phase  [4];
      int stall_by_phase [4];

      first_scan = '{8'hFF, 8'h01, 8'h80, 8'h00, 8'h55, 8'hAA, 8'h0F, 8'hF0,
                     8'h3C, 8'hC3, 8'h00, 8'hFF, 8'hFF, 8'h5A, 8'hA5, 8'h00};
      idle_by_phase  = '{0, 71, 0, 20};
      stall_by_phase = '{0, 0, 71, 20};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: one full scan at reset settings. Row 0 all keys down gives
      // the full eight events; unchanged and control rows give none.
      foreach (first_scan[i]) queue_sample(first_scan[i]);
      wait_drained();

      // Octave 9 and full velocity: releasing row 0 now drops the notes
      // that land above 127.
      write_csr(CSR_OCTAVE_OFFSET, 8'd9);
      write_csr(CSR_NOTE_VELOCITY, 8'd127);
      repeat (6) queue_sample(8'h00);
      wait_drained();

      // unmapped indexes are ignored; upper data bits are cut off
      write_csr(CSR_UNMAPPED_LOW, 8'h00);
      write_csr(CSR_UNMAPPED_TOP, 8'hFF);
      write_csr(CSR_OCTAVE_OFFSET, 8'hF3);
      write_csr(CSR_NOTE_VELOCITY, 8'h85);
      repeat (4) queue_sample(8'hFF);
      wait_drained();

      // Random phases, each with its own idle pattern and settings.
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               write_csr(CSR_OCTAVE_OFFSET, 8'd0);
               write_csr(CSR_NOTE_VELOCITY, 8'd0);
            end
            1: begin
               write_csr(CSR_OCTAVE_OFFSET, 8'd9);
               write_csr(CSR_NOTE_VELOCITY, 8'd127);
            end
            default: begin
               write_csr(CSR_OCTAVE_OFFSET, 8'($urandom));
               write_csr(CSR_NOTE_VELOCITY, 8'($urandom));
            end
         endcase
         sender_idle_pct    = idle_by_phase[p];
         receiver_stall_pct = stall_by_phase[p];
         repeat (HALF_PHASE) queue_sample(random_sample());
         wait_drained();     // hold-off mid phase until all events are back
         repeat (HALF_PHASE) queue_sample(random_sample());
         wait_drained();
         sender_idle_pct    = 0;
         receiver_stall_pct = 0;
      end

      $display("Run covered %0d column samples over several octave and velocity settings,",
               items_accepted);
      $display("with %0d note events checked and %0d register writes.",
               events_checked, csr_writes);
      if (error_count == 0 && expected_events.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
